FILE: src/sbbc_pkg.sv
// Shared codes and types for the segment/box boundary crossing block.
package sbbc_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOCROSS = 2'd1,
        ST_DEGEN   = 2'd2
    } t_status;

    localparam logic [1:0] EDGE_XMAX = 2'd0;
    localparam logic [1:0] EDGE_YMAX = 2'd1;
    localparam logic [1:0] EDGE_XMIN = 2'd2;
    localparam logic [1:0] EDGE_YMIN = 2'd3;

    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MAX_X = 2'd1;
    localparam logic [1:0] REG_MIN_Y = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Outcome of the edge tests, handed from the front end to the back end.
    typedef struct packed {
        t_status    status;
        logic [1:0] edge_id;
        logic       horiz;
        logic       use2;
    } t_cls;

endpackage

FILE: src/sbbc_rdiv.sv
// Pipelined rounding divider: round(num/den), ties away from zero, clamped to 2^W.
module sbbc_rdiv #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2*W+1:0]       i_num,
    input  logic [W:0]           i_den,
    input  logic                 i_neg,
    output logic signed [W+1:0]  o_quot
);
    localparam int S = W + 1;
    localparam logic [W+1:0] LIM = (W+2)'(1) << W;

    logic [W:0] r_rem [S+1];
    logic [W:0] r_nlo [S+1];
    logic [W:0] r_q   [S+1];
    logic [W:0] r_den [S+1];
    logic       r_ovf [S+1];
    logic       r_neg [S+1];

    logic [W:0]   n_hi;
    logic [W+1:0] n_qr;
    logic [W+1:0] n_mag;
    logic         n_up;

    assign n_hi = i_num[2*W+1 -: W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi;
            r_nlo[0] <= i_num[W:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= (n_hi >= i_den);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar s = 1; s <= S; s++) begin : g_step
        logic [W+1:0] n_t;
        logic [W+1:0] n_d;
        logic         n_ge;

        assign n_t  = {r_rem[s-1], r_nlo[s-1][W]};
        assign n_ge = n_t >= {1'b0, r_den[s-1]};
        assign n_d  = n_t - {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_ge ? n_d[W:0] : n_t[W:0];
                r_nlo[s] <= {r_nlo[s-1][W-1:0], 1'b0};
                r_q[s]   <= {r_q[s-1][W-1:0], n_ge};
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    // round half up on the magnitude, then clamp
    assign n_up  = {r_rem[S], 1'b0} >= {1'b0, r_den[S]};
    assign n_qr  = {1'b0, r_q[S]} + (W+2)'(n_up);
    assign n_mag = (r_ovf[S] || n_qr > LIM) ? LIM : n_qr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quot <= r_neg[S] ? -$signed(n_mag) : $signed(n_mag);
        end
    end

endmodule

FILE: src/sbbc_queue.sv
// Short item queue between the classifying front end and the back end.
module sbbc_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import sbbc_pkg::*;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

FILE: src/sbbc_front.sv
// Front end: accepts segments, runs the orientation tests and picks the crossed edge.
module sbbc_front #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [W-1:0] i_start_x,
    input  logic signed [W-1:0] i_start_y,
    input  logic signed [W-1:0] i_end_x,
    input  logic signed [W-1:0] i_end_y,
    input  logic signed [W-1:0] i_min_x,
    input  logic signed [W-1:0] i_max_x,
    input  logic signed [W-1:0] i_min_y,
    input  logic signed [W-1:0] i_max_y,
    input  logic                i_q_full,
    output logic                o_push,
    output sbbc_pkg::t_cls      o_cls,
    output logic signed [W-1:0] o_x1,
    output logic signed [W-1:0] o_y1,
    output logic signed [W-1:0] o_bnd,
    output logic signed [W:0]   o_dx1,
    output logic signed [W:0]   o_dy1
);
    import sbbc_pkg::*;

    localparam int PW = 2*W + 2;

    logic fe;

    // stage 1: differences and edge-side tests
    logic signed [W:0]   n_dx1, n_dy1, n_wh, n_wl, n_uh, n_ul;
    logic [W:0]          n_mdx1, n_mdx2;
    logic signed [W-1:0] n_ec [4];
    logic signed [W-1:0] n_pa [4];
    logic signed [W-1:0] n_pb [4];
    logic [3:0]          n_nz2, n_p34pos, n_p34zero, n_degen;

    logic                r_f1_valid;
    logic signed [W-1:0] r_f1_x1, r_f1_y1;
    logic signed [W:0]   r_f1_dx1, r_f1_dy1, r_f1_wh, r_f1_wl, r_f1_uh, r_f1_ul;
    logic [3:0]          r_f1_p34pos, r_f1_p34zero, r_f1_degen;
    logic                r_f1_use2;

    // stage 2: cross products
    logic                 r_f2_valid;
    logic signed [W-1:0]  r_f2_x1, r_f2_y1;
    logic signed [W:0]    r_f2_dx1, r_f2_dy1;
    logic signed [PW-1:0] r_f2_pul, r_f2_puh, r_f2_pwh, r_f2_pwl;
    logic [3:0]           r_f2_p34pos, r_f2_p34zero, r_f2_degen;
    logic                 r_f2_use2;

    logic signed [PW:0] n_d [4];
    logic [3:0]         n_oneg, n_ozero, n_cross;
    logic               n_found;
    logic [1:0]         n_sel;

    assign fe      = !r_f2_valid || !i_q_full;
    assign o_stall = !fe;
    assign o_push  = r_f2_valid && fe;

    always_comb begin
        n_dx1  = (W+1)'(i_end_x) - (W+1)'(i_start_x);
        n_dy1  = (W+1)'(i_end_y) - (W+1)'(i_start_y);
        n_wh   = (W+1)'(i_max_x) - (W+1)'(i_start_x);
        n_wl   = (W+1)'(i_min_x) - (W+1)'(i_start_x);
        n_uh   = (W+1)'(i_max_y) - (W+1)'(i_start_y);
        n_ul   = (W+1)'(i_min_y) - (W+1)'(i_start_y);
        n_mdx1 = n_dx1[W] ? (W+1)'(-n_dx1) : (W+1)'(n_dx1);
        n_mdx2 = (i_max_x >= i_min_x) ? (W+1)'((W+1)'(i_max_x) - (W+1)'(i_min_x))
                                      : (W+1)'((W+1)'(i_min_x) - (W+1)'(i_max_x));
        // edge line and the two segment coordinates tested against it
        n_ec[0] = i_max_x; n_pa[0] = i_start_x; n_pb[0] = i_end_x;
        n_ec[1] = i_max_y; n_pa[1] = i_start_y; n_pb[1] = i_end_y;
        n_ec[2] = i_min_x; n_pa[2] = i_start_x; n_pb[2] = i_end_x;
        n_ec[3] = i_min_y; n_pa[3] = i_start_y; n_pb[3] = i_end_y;
        n_nz2[0] = i_max_y != i_min_y;
        n_nz2[2] = n_nz2[0];
        n_nz2[1] = i_max_x != i_min_x;
        n_nz2[3] = n_nz2[1];
        for (int e = 0; e < 4; e++) begin
            n_p34zero[e] = !n_nz2[e] || (n_pa[e] == n_ec[e]) || (n_pb[e] == n_ec[e]);
            n_p34pos[e]  = !n_p34zero[e] && ((n_pa[e] > n_ec[e]) == (n_pb[e] > n_ec[e]));
            n_degen[e]   = !n_nz2[e] || (e[0] ? (n_dy1 == '0) : (n_dx1 == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (fe) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_f1_x1      <= i_start_x;
            r_f1_y1      <= i_start_y;
            r_f1_dx1     <= n_dx1;
            r_f1_dy1     <= n_dy1;
            r_f1_wh      <= n_wh;
            r_f1_wl      <= n_wl;
            r_f1_uh      <= n_uh;
            r_f1_ul      <= n_ul;
            r_f1_p34pos  <= n_p34pos;
            r_f1_p34zero <= n_p34zero;
            r_f1_degen   <= n_degen;
            r_f1_use2    <= n_mdx1 > n_mdx2;

            r_f2_x1      <= r_f1_x1;
            r_f2_y1      <= r_f1_y1;
            r_f2_dx1     <= r_f1_dx1;
            r_f2_dy1     <= r_f1_dy1;
            r_f2_pul     <= PW'(r_f1_dx1) * PW'(r_f1_ul);
            r_f2_puh     <= PW'(r_f1_dx1) * PW'(r_f1_uh);
            r_f2_pwh     <= PW'(r_f1_dy1) * PW'(r_f1_wh);
            r_f2_pwl     <= PW'(r_f1_dy1) * PW'(r_f1_wl);
            r_f2_p34pos  <= r_f1_p34pos;
            r_f2_p34zero <= r_f1_p34zero;
            r_f2_degen   <= r_f1_degen;
            r_f2_use2    <= r_f1_use2;
        end
    end

    // stage 3: orientation of each box corner against the segment, first crossed edge
    always_comb begin
        n_d[0] = (PW+1)'(r_f2_pul) - (PW+1)'(r_f2_pwh);
        n_d[1] = (PW+1)'(r_f2_puh) - (PW+1)'(r_f2_pwh);
        n_d[2] = (PW+1)'(r_f2_puh) - (PW+1)'(r_f2_pwl);
        n_d[3] = (PW+1)'(r_f2_pul) - (PW+1)'(r_f2_pwl);
        for (int k = 0; k < 4; k++) begin
            n_oneg[k]  = n_d[k][PW];
            n_ozero[k] = n_d[k] == '0;
        end
        for (int e = 0; e < 4; e++) begin
            n_cross[e] = !(!n_ozero[e] && !n_ozero[(e+1)%4] && (n_oneg[e] == n_oneg[(e+1)%4]))
                         && !r_f2_p34pos[e]
                         && !((n_ozero[e] || n_ozero[(e+1)%4]) && r_f2_p34zero[e]);
        end
        n_found = 1'b0;
        n_sel   = EDGE_XMAX;
        for (int e = 3; e >= 0; e--) begin
            if (n_cross[e]) begin
                n_found = 1'b1;
                n_sel   = 2'(e);
            end
        end
    end

    always_comb begin
        o_cls.status  = !n_found ? ST_NOCROSS : (r_f2_degen[n_sel] ? ST_DEGEN : ST_OK);
        o_cls.edge_id = n_sel;
        o_cls.horiz   = n_sel[0];
        o_cls.use2    = n_sel[0] ? r_f2_use2 : 1'b1;
        unique case (n_sel)
            EDGE_XMAX: o_bnd = i_max_x;
            EDGE_YMAX: o_bnd = i_max_y;
            EDGE_XMIN: o_bnd = i_min_x;
            EDGE_YMIN: o_bnd = i_min_y;
            default:   o_bnd = i_max_x;
        endcase
    end

    assign o_x1  = r_f2_x1;
    assign o_y1  = r_f2_y1;
    assign o_dx1 = r_f2_dx1;
    assign o_dy1 = r_f2_dy1;

endmodule

FILE: src/sbbc_back.sv
// Back end: the two rounding divisions that place the crossing point, and the output register.
module sbbc_back #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  sbbc_pkg::t_cls      i_cls,
    input  logic signed [W-1:0] i_x1,
    input  logic signed [W-1:0] i_y1,
    input  logic signed [W-1:0] i_bnd,
    input  logic signed [W:0]   i_dx1,
    input  logic signed [W:0]   i_dy1,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [W-1:0] o_cross_x,
    output logic signed [W-1:0] o_cross_y,
    output logic [1:0]          o_edge_hit,
    output logic [1:0]          o_status
);
    import sbbc_pkg::*;

    localparam int PW      = 2*W + 2;
    localparam int DIV_LAT = W + 3;

    typedef struct packed {
        t_cls                cls;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] bnd;
        logic signed [W-1:0] xr;
        logic signed [W:0]   dx1;
        logic signed [W:0]   dy1;
    } t_sb;

    function automatic logic [W:0] f_mag(input logic signed [W:0] v);
        f_mag = v[W] ? (W+1)'(-v) : (W+1)'(v);
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+2:0] v);
        if (v[W+2:W-1] == '0 || v[W+2:W-1] == '1) f_sat = v[W-1:0];
        else f_sat = v[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    logic adv;

    logic                  r_v0;
    t_sb                   r_sb0;
    logic [PW-1:0]         r_prod0;
    logic [W:0]            r_den0;
    logic                  r_neg0;
    logic signed [W:0]     n_b1;

    logic [DIV_LAT-1:0]    r_v1;
    t_sb                   r_sb1 [DIV_LAT];
    logic signed [W+1:0]   q1;

    logic                  r_v2;
    t_sb                   r_sb2;

    logic                  r_v3;
    t_sb                   r_sb3;
    logic [PW-1:0]         r_prod3;
    logic [W:0]            r_den3;
    logic                  r_neg3;
    logic signed [W:0]     n_b2;

    logic [DIV_LAT-1:0]    r_v4;
    t_sb                   r_sb4 [DIV_LAT];
    logic signed [W+1:0]   q2;

    logic signed [W-1:0]   n_y;
    t_sb                   n_sb0;
    t_sb                   n_sb2;
    t_sb                   sbq;

    logic                  r_out_valid;

    // the whole back end moves together unless a finished item is held
    assign adv     = !r_out_valid || !i_stall;
    assign o_q_pop = adv && i_q_valid;

    always_comb begin
        n_sb0.cls = i_cls;
        n_sb0.x1  = i_x1;
        n_sb0.y1  = i_y1;
        n_sb0.bnd = i_bnd;
        n_sb0.xr  = i_bnd;
        n_sb0.dx1 = i_dx1;
        n_sb0.dy1 = i_dy1;
        n_b1      = (W+1)'(i_bnd) - (W+1)'(i_y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= '0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v0        <= o_q_pop;
            r_v1        <= {r_v1[DIV_LAT-2:0], r_v0};
            r_v2        <= r_v1[DIV_LAT-1];
            r_v3        <= r_v2;
            r_v4        <= {r_v4[DIV_LAT-2:0], r_v3};
            r_out_valid <= r_v4[DIV_LAT-1];
        end
    end

    // x on a horizontal edge: x1 + dx1*(cy-y1)/dy1
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb0   <= n_sb0;
            r_prod0 <= PW'(f_mag(i_dx1)) * PW'(f_mag(n_b1));
            r_den0  <= f_mag(i_dy1);
            r_neg0  <= i_dx1[W] ^ n_b1[W] ^ i_dy1[W];
        end
    end

    sbbc_rdiv #(.W(W)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r_prod0),
        .i_den  (r_den0),
        .i_neg  (r_neg0),
        .o_quot (q1)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb1[0] <= r_sb0;
            for (int j = 1; j < DIV_LAT; j++) r_sb1[j] <= r_sb1[j-1];
        end
    end

    always_comb begin
        n_sb2 = r_sb1[DIV_LAT-1];
        if (n_sb2.cls.horiz) n_sb2.xr = f_sat((W+3)'(n_sb2.x1) + (W+3)'(q1));
        n_b2 = (W+1)'(r_sb2.xr) - (W+1)'(r_sb2.x1);
    end

    // y on the line with the larger x extent: y1 + dy1*(X-x1)/dx1
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb2   <= n_sb2;
            r_sb3   <= r_sb2;
            r_prod3 <= PW'(f_mag(r_sb2.dy1)) * PW'(f_mag(n_b2));
            r_den3  <= f_mag(r_sb2.dx1);
            r_neg3  <= r_sb2.dy1[W] ^ n_b2[W] ^ r_sb2.dx1[W];
        end
    end

    sbbc_rdiv #(.W(W)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r_prod3),
        .i_den  (r_den3),
        .i_neg  (r_neg3),
        .o_quot (q2)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb4[0] <= r_sb3;
            for (int j = 1; j < DIV_LAT; j++) r_sb4[j] <= r_sb4[j-1];
        end
    end

    assign sbq = r_sb4[DIV_LAT-1];
    assign n_y = sbq.cls.use2 ? f_sat((W+3)'(sbq.y1) + (W+3)'(q2)) : sbq.bnd;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_cross_x  <= (sbq.cls.status == ST_OK) ? sbq.xr : '0;
            o_cross_y  <= (sbq.cls.status == ST_OK) ? n_y : '0;
            o_edge_hit <= (sbq.cls.status == ST_NOCROSS) ? EDGE_XMAX : sbq.cls.edge_id;
            o_status   <= sbq.cls.status;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: src/segment_box_boundary_crossing_core.sv
// Top level: box registers, front end, item queue and back end of the boundary crossing block.
//
// Finds where a segment crosses the boundary of the box held in the four registers, trying the
// edges x=max, y=max, x=min, y=min in that order. One item is taken every cycle while o_stall
// is low. An item passes the second front stage, the four-entry queue, two pipelined dividers
// of COORD_BITS+3 stages each and four further back-end registers before o_valid rises. A stall
// on the output freezes the back end; the queue absorbs the front end's items in flight. Write the
// registers only while no item is in the block.
module segment_box_boundary_crossing_core #(
    parameter int COORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [COORD_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS-1:0] o_cross_y,
    output logic [1:0]            o_edge_hit,
    output logic [1:0]            o_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [((COORD_BITS > 32) ? 5 : 4)-1:0] paddr,
    input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                  pready
);
    import sbbc_pkg::*;

    localparam int W       = COORD_BITS;
    localparam int ADDR_W  = (COORD_BITS > 32) ? 5 : 4;
    localparam int PDATA_W = (COORD_BITS > 32) ? 64 : 32;

    typedef struct packed {
        t_cls                cls;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] bnd;
        logic signed [W:0]   dx1;
        logic signed [W:0]   dy1;
    } t_job;

    logic signed [W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [1:0]          reg_idx;
    logic signed [W-1:0] rd_val;

    t_job f_job, q_job;
    logic f_push, q_full, q_valid, q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1 -: 2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_MIN_X: r_min_x <= pwdata[W-1:0];
                REG_MAX_X: r_max_x <= pwdata[W-1:0];
                REG_MIN_Y: r_min_y <= pwdata[W-1:0];
                REG_MAX_Y: r_max_y <= pwdata[W-1:0];
                default:   r_min_x <= r_min_x;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_X: rd_val = r_min_x;
            REG_MAX_X: rd_val = r_max_x;
            REG_MIN_Y: rd_val = r_min_y;
            REG_MAX_Y: rd_val = r_max_y;
            default:   rd_val = r_min_x;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);

    sbbc_front #(.W(W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_min_x   (r_min_x),
        .i_max_x   (r_max_x),
        .i_min_y   (r_min_y),
        .i_max_y   (r_max_y),
        .i_q_full  (q_full),
        .o_push    (f_push),
        .o_cls     (f_job.cls),
        .o_x1      (f_job.x1),
        .o_y1      (f_job.y1),
        .o_bnd     (f_job.bnd),
        .o_dx1     (f_job.dx1),
        .o_dy1     (f_job.dy1)
    );

    sbbc_queue #(.DATA_W($bits(t_job))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    sbbc_back #(.W(W)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_cls      (q_job.cls),
        .i_x1       (q_job.x1),
        .i_y1       (q_job.y1),
        .i_bnd      (q_job.bnd),
        .i_dx1      (q_job.dx1),
        .i_dy1      (q_job.dy1),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cross_x  (o_cross_x),
        .o_cross_y  (o_cross_y),
        .o_edge_hit (o_edge_hit),
        .o_status   (o_status)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("item pushed into a full queue");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("crossing point not zero on a failed item");

    a_nocross_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOCROSS) |-> o_edge_hit == EDGE_XMAX)
        else $error("edge reported on an item with no crossing");

    a_vertical_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && o_edge_hit == EDGE_XMAX) |-> o_cross_x == r_max_x)
        else $error("crossing on x=max edge off the edge");

endmodule

FILE: verif/segment_box_boundary_crossing_core_tb.sv
// Self-checking testbench for the segment/box boundary crossing block.
module segment_box_boundary_crossing_core_tb;
    import sbbc_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN_WAIT  = 200;
    localparam int ITEMS_PHASE = 180;
    localparam int NUM_PHASES  = 7;

    localparam logic signed [31:0] ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] TWO   = 32'sh0002_0000;
    localparam logic signed [31:0] HALF  = 32'sh0000_8000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         edge_id;
        t_status            st;
    } t_crossing;

    typedef struct {
        logic signed [31:0] sx, sy, ex, ey;
        bit                 chk;
        logic signed [31:0] ox, oy;
        logic [1:0]         oe;
        t_status            os;
    } t_seg_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_cross_x, o_cross_y;
    logic [1:0]         o_edge_hit, o_status;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic signed [31:0] box_lx = '0, box_hx = '0, box_ly = '0, box_hy = '0;
    t_crossing          pending_crossings[$];
    int                 fail_count = 0;

    segment_box_boundary_crossing_core u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_start_x, .i_start_y, .i_end_x, .i_end_y,
        .o_valid, .i_stall, .o_cross_x, .o_cross_y, .o_edge_hit, .o_status,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [127:0] abs_wide(longint v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic int orient_sign(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        logic signed [127:0] a, b, c, d, t;
        a = qx - px;
        b = ry - py;
        c = qy - py;
        d = rx - px;
        t = a * b - c * d;
        return (t > 0) ? 1 : ((t < 0) ? -1 : 0);
    endfunction

    // round(a*b/c) to nearest, ties away from zero, magnitude capped at 2^62
    function automatic longint scaled_quot(longint a, longint b, longint c);
        logic [127:0] n, d, q, r;
        bit           neg;
        n = abs_wide(a) * abs_wide(b);
        d = abs_wide(c);
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        if (q > (128'd1 << 62)) q = 128'd1 << 62;
        neg = ((a < 0) ^ (b < 0) ^ (c < 0)) && a != 0 && b != 0;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(C_MAX)) return C_MAX;
        if (v < longint'(C_MIN)) return C_MIN;
        return v[31:0];
    endfunction

    function automatic t_crossing predict_crossing(logic signed [31:0] sx, sy, ex, ey);
        t_crossing res;
        longint    x1, y1, x2, y2, dx1, dy1, cx, cy, qx, qy, dx2, dy2;
        longint    px[5], py[5];
        logic signed [31:0] xr, yr;
        int        p12, p34;
        x1 = sx; y1 = sy; x2 = ex; y2 = ey;
        dx1 = x2 - x1;
        dy1 = y2 - y1;
        px = '{box_hx, box_hx, box_lx, box_lx, box_hx};
        py = '{box_ly, box_hy, box_hy, box_ly, box_ly};
        res = '{x: '0, y: '0, edge_id: EDGE_XMAX, st: ST_NOCROSS};
        for (int e = 0; e < 4; e++) begin
            cx = px[e]; cy = py[e]; qx = px[e+1]; qy = py[e+1];
            dx2 = qx - cx;
            dy2 = qy - cy;
            p12 = orient_sign(x1, y1, x2, y2, cx, cy) * orient_sign(x1, y1, x2, y2, qx, qy);
            p34 = orient_sign(cx, cy, qx, qy, x1, y1) * orient_sign(cx, cy, qx, qy, x2, y2);
            if (p12 > 0 || p34 > 0 || (p12 == 0 && p34 == 0)) continue;
            res.edge_id = e[1:0];
            if (e % 2 == 0) begin
                if (dx1 == 0 || dy2 == 0) begin
                    res.st = ST_DEGEN;
                    return res;
                end
                xr = cx[31:0];
                yr = clamp32(y1 + scaled_quot(dy1, longint'(xr) - x1, dx1));
            end else begin
                if (dy1 == 0 || dx2 == 0) begin
                    res.st = ST_DEGEN;
                    return res;
                end
                xr = clamp32(x1 + scaled_quot(dx1, cy - y1, dy1));
                if (abs_wide(dx1) > abs_wide(dx2))
                    yr = clamp32(y1 + scaled_quot(dy1, longint'(xr) - x1, dx1));
                else
                    yr = cy[31:0];
            end
            res.x  = xr;
            res.y  = yr;
            res.st = ST_OK;
            return res;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_crossings.size() == 0) begin
                $display("%0t: result with none expected: x=%h y=%h edge=%0d status=%0d",
                         $time, o_cross_x, o_cross_y, o_edge_hit, o_status);
                fail_count++;
            end else begin
                want = pending_crossings.pop_front();
                if (o_cross_x !== want.x) begin
                    $display("%0t: cross_x expected %h actual %h", $time, want.x, o_cross_x);
                    fail_count++;
                end
                if (o_cross_y !== want.y) begin
                    $display("%0t: cross_y expected %h actual %h", $time, want.y, o_cross_y);
                    fail_count++;
                end
                if (o_edge_hit !== want.edge_id) begin
                    $display("%0t: edge_hit expected %0d actual %0d",
                             $time, want.edge_id, o_edge_hit);
                    fail_count++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, o_status);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure: periodically switch to one of four random stall patterns
    always @(negedge i_clk) begin
        int unsigned cyc;
        int unsigned mode;
        cyc++;
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            2: i_stall <= ((cyc % 16) < 9);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // ---------------------------------------------------------------- stimulus
    task automatic reg_write(logic [1:0] idx, logic signed [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_X: box_lx = val;
            REG_MAX_X: box_hx = val;
            REG_MIN_Y: box_ly = val;
            default:   box_hy = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_crossings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_box(logic signed [31:0] lx, hx, ly, hy);
        wait_idle();
        reg_write(REG_MIN_X, lx);
        reg_write(REG_MAX_X, hx);
        reg_write(REG_MIN_Y, ly);
        reg_write(REG_MAX_Y, hy);
    endtask

    int burst_left = 0;

    // present one item, hold it until taken; insert a random gap between bursts
    task automatic send_segment(logic signed [31:0] sx, sy, ex, ey, output t_crossing got);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = predict_crossing(sx, sy, ex, ey);
        pending_crossings.insert(pending_crossings.size(), got);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid   <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo, hi);
        longint a, b, span, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a + 4;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return lo;
                    1: return hi;
                    2: return C_MIN;
                    default: return C_MAX;
                endcase
            end
            2: return clamp32(longint'(lo) + $urandom_range(0, 4) - 2);
            default: begin
                v = longint'({$urandom, $urandom} >> 1);
                return clamp32(a - span / 2 + v % (2 * span));
            end
        endcase
    endfunction

    t_seg_row seg_rows[] = '{
        // reset box: all edges collapse to the origin
        '{-ONE, 0, ONE, 0, 1, 0, 0, EDGE_XMAX, ST_NOCROSS},
        '{C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0, EDGE_XMAX, ST_OK},
        // unit box from here on
        '{0, 0, 0, 0, 1, 0, 0, EDGE_XMAX, ST_NOCROSS},
        '{-TWO, 0, TWO, 0, 1, ONE, 0, EDGE_XMAX, ST_OK},
        '{TWO, 0, -TWO, 0, 1, ONE, 0, EDGE_XMAX, ST_OK},
        '{0, 0, 0, TWO, 1, 0, ONE, EDGE_YMAX, ST_OK},
        '{-TWO, HALF, 0, HALF, 1, -ONE, HALF, EDGE_XMIN, ST_OK},
        '{0, -TWO, 0, 0, 1, 0, -ONE, EDGE_YMIN, ST_OK},
        '{TWO, TWO, 3 * ONE, 3 * ONE, 1, 0, 0, EDGE_XMAX, ST_NOCROSS},
        '{ONE, -TWO, ONE, TWO, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{-ONE, -TWO, -ONE, TWO, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{ONE, ONE, TWO, TWO, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{C_MAX, C_MAX, C_MIN, C_MIN, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{C_MIN, 0, C_MAX, 0, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{0, C_MIN, 0, C_MAX, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{HALF, HALF, 3 * ONE, 7, 0, 0, 0, EDGE_XMAX, ST_OK},
        '{32'sh0001_2345, 32'shFFFF_8001, 32'shFFFE_0001, 32'sh0002_7FFF,
          0, 0, 0, EDGE_XMAX, ST_OK},
        '{32'sh0000_0001, 32'shFFFF_0000, 32'shFFFF_FFFF, 32'sh0001_0000,
          0, 0, 0, EDGE_XMAX, ST_OK}
    };

    initial begin
        t_crossing          got;
        logic signed [31:0] sx, sy, ex, ey;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (seg_rows[i]) begin
            if (i == 2) begin
                stop_sending();
                load_box(-ONE, ONE, -ONE, ONE);
            end
            send_segment(seg_rows[i].sx, seg_rows[i].sy, seg_rows[i].ex, seg_rows[i].ey, got);
            if (seg_rows[i].chk && (got.x !== seg_rows[i].ox || got.y !== seg_rows[i].oy ||
                    got.edge_id !== seg_rows[i].oe || got.st !== seg_rows[i].os)) begin
                $display("%0t: row %0d prediction expected %h %h %0d %0d actual %h %h %0d %0d",
                         $time, i, seg_rows[i].ox, seg_rows[i].oy, seg_rows[i].oe,
                         seg_rows[i].os, got.x, got.y, got.edge_id, got.st);
                fail_count++;
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            stop_sending();
            case (p)
                0: load_box(-ONE, ONE, -ONE, ONE);
                1: load_box(C_MIN, C_MAX, C_MIN, C_MAX);
                2: load_box(ONE, -ONE, TWO, -TWO);
                3: load_box(0, 0, 0, 0);
                4: load_box(C_MAX, C_MAX, C_MIN, C_MIN);
                5: begin
                    sx = $urandom_range(0, 32'h0004_0000);
                    sy = $urandom_range(0, 32'h0004_0000);
                    load_box(-sx, sx + 1, -sy, sy + 1);
                end
                default: load_box($urandom, $urandom, $urandom, $urandom);
            endcase
            repeat (ITEMS_PHASE) begin
                sx = pick_coord(box_lx, box_hx);
                sy = pick_coord(box_ly, box_hy);
                ex = pick_coord(box_lx, box_hx);
                ey = pick_coord(box_ly, box_hy);
                case ($urandom_range(0, 15))
                    0, 1: ex = sx;
                    2, 3: ey = sy;
                    4: begin
                        ex = sx;
                        ey = sy;
                    end
                    default: ;
                endcase
                send_segment(sx, sy, ex, ey, got);
            end
        end

        stop_sending();
        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
